@@ hw/rtl/bbe_pkg.sv @@
// ---------------------------------------------------------------------------
// bbe_pkg: shared types and constants for the big-endian byte RAM
// Word layouts, size decode, status codes and the per-bank request record.
// ---------------------------------------------------------------------------
package bbe_pkg;

  // Geometry
  localparam int SLOT_BYTES  = 4096;
  localparam int SLOT_LIMIT  = 16;
  localparam int NUM_BANKS   = 4;
  localparam int RAM_BYTES   = SLOT_BYTES * SLOT_LIMIT;
  localparam int BANK_DEPTH  = RAM_BYTES / NUM_BANKS;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int SIZE_W      = $clog2(RAM_BYTES + 1);
  localparam int SLOTS_W     = 5;
  localparam int LIMIT_W     = 9;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } out_word_t;

  // One bank's access for a cycle
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ROW_W-1:0] row;
    logic [7:0]       wdata;
  } bank_req_t;

  // Bytes moved by a size code; any code but byte and word acts as four bytes
  function automatic logic [2:0] byte_count(input logic [1:0] code);
    logic [2:0] n;
    n = 3'd4;
    if (code == SZ_BYTE) n = 3'd1;
    else if (code == SZ_WORD) n = 3'd2;
    return n;
  endfunction

endpackage

@@ hw/rtl/bbe_ram.sv @@
// ---------------------------------------------------------------------------
// bbe_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered and held.
// ---------------------------------------------------------------------------
module bbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bbe_bank_map.sv @@
// ---------------------------------------------------------------------------
// bbe_bank_map: byte lane steering onto the four banks
// Maps a big-endian access of 1, 2 or 4 bytes to per-bank row, enable and
// data; during the clearing pass every bank writes zero at the sweep row.
// ---------------------------------------------------------------------------
module bbe_bank_map (
  input  bbe_pkg::in_word_t                         req,
  input  logic                                      issue_wr,
  input  logic                                      issue_rd,
  input  logic                                      clr,
  input  logic [bbe_pkg::ROW_W-1:0]                 clr_row,
  output bbe_pkg::bank_req_t [bbe_pkg::NUM_BANKS-1:0] bank_req
);

  logic [1:0]                off;
  logic [2:0]                cnt;
  logic [bbe_pkg::ROW_W-1:0] row_base;

  assign off      = req.address[1:0];
  assign cnt      = bbe_pkg::byte_count(req.access_size);
  assign row_base = req.address[bbe_pkg::ROW_W+1:2];

  // Per-bank steering: bank b holds byte i = (b - off) mod 4 of the access
  always_comb begin
    logic [1:0] i;
    logic [1:0] k;
    for (int b = 0; b < bbe_pkg::NUM_BANKS; b++) begin
      i = 2'(b) - off;
      k = 2'(cnt - 3'd1 - {1'b0, i});
      if (clr) begin
        bank_req[b].we    = 1'b1;
        bank_req[b].re    = 1'b0;
        bank_req[b].row   = clr_row;
        bank_req[b].wdata = 8'h00;
      end else begin
        bank_req[b].we    = issue_wr && ({1'b0, i} < cnt);
        bank_req[b].re    = issue_rd;
        bank_req[b].row   = row_base + ((2'(b) < off) ? bbe_pkg::ROW_W'(1)
                                                       : bbe_pkg::ROW_W'(0));
        bank_req[b].wdata = req.write_data[8*k +: 8];
      end
    end
  end

endmodule

@@ hw/rtl/bounded_big_endian_ram.sv @@
// ---------------------------------------------------------------------------
// bounded_big_endian_ram: byte-addressed RAM behind a big-endian port
// Reads and writes 1, 2 or 4 bytes at any byte address, bounded by the
// configured number of active slots; four byte banks serve a whole access.
// ---------------------------------------------------------------------------
//
//  port group | direction | handshake          | word
//  -----------+-----------+--------------------+--------------------------
//  in_        | in        | in_valid/in_stall  | opcode, size, addr, data
//  out_       | out       | out_valid/out_stall| read_data, status
//  cfg_       | in        | cfg_we             | active_slots (5 bits)
//
//  Each word and its bank read are registered on acceptance, then loaded
//  into the output register; with no output stall a new word is accepted
//  every cycle. After reset a clearing pass zeroes the banks, one row per
//  cycle, across all BANK_DEPTH (16384) rows; in_stall is high throughout.
//  While the output register is held by out_stall, one word may be pending
//  and in_stall rises until the output register frees up.
// ---------------------------------------------------------------------------
module bounded_big_endian_ram (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bbe_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bbe_pkg::out_word_t           out_word,
  input  logic                         cfg_we,
  input  logic [bbe_pkg::SLOTS_W-1:0]  cfg_wdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_BUSY  = 2'd2;

  localparam logic [bbe_pkg::ROW_W-1:0] LAST_ROW =
    bbe_pkg::ROW_W'(bbe_pkg::BANK_DEPTH - 1);
  localparam logic [bbe_pkg::SIZE_W-1:0] SLOT_SIZE =
    bbe_pkg::SIZE_W'(bbe_pkg::SLOT_BYTES);
  localparam logic [bbe_pkg::LIMIT_W-1:0] LIMIT =
    bbe_pkg::LIMIT_W'(bbe_pkg::SLOT_LIMIT);

  logic [1:0]                  state_r, state_nxt;
  logic [bbe_pkg::ROW_W-1:0]   clr_row_r, clr_row_nxt;
  logic [bbe_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [1:0]                  pend_status_r, pend_status_nxt;
  logic                        pend_rd_r, pend_rd_nxt;
  logic [1:0]                  pend_off_r, pend_off_nxt;
  logic [1:0]                  pend_code_r, pend_code_nxt;
  logic                        out_valid_r, out_valid_nxt;
  bbe_pkg::out_word_t          out_word_r, out_word_nxt;

  logic                        accept;
  logic                        out_load;
  logic [2:0]                  cnt;
  logic [32:0]                 addr_x;
  logic [32:0]                 end_x;
  logic [32:0]                 size_x;
  logic [1:0]                  status;
  logic                        ok;
  logic [bbe_pkg::LIMIT_W-1:0] slots;

  bbe_pkg::bank_req_t [bbe_pkg::NUM_BANKS-1:0] bank_req;
  logic [bbe_pkg::NUM_BANKS-1:0][7:0]          bank_rdata;

  // Handshake
  assign out_load = (state_r == S_BUSY) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r == S_CLEAR) || ((state_r == S_BUSY) && !out_load);
  assign accept   = in_valid && !in_stall;

  // Bounds check against the usable size
  assign cnt    = bbe_pkg::byte_count(in_word.access_size);
  assign addr_x = {1'b0, in_word.address};
  assign end_x  = addr_x + 33'(cnt);
  assign size_x = 33'(size_r);

  always_comb begin
    if (addr_x >= size_x) status = bbe_pkg::ST_INVALID;
    else if (end_x > size_x) status = bbe_pkg::ST_OVERFLOW;
    else status = bbe_pkg::ST_OK;
  end

  assign ok = (status == bbe_pkg::ST_OK);

  // Usable size from a slot count write, clamped to the slot limit
  assign slots = ({4'd0, cfg_wdata} > LIMIT) ? LIMIT : {4'd0, cfg_wdata};
  assign size_nxt = cfg_we ? bbe_pkg::SIZE_W'(bbe_pkg::SIZE_W'(slots) * SLOT_SIZE)
                           : size_r;

  // Bank steering and storage
  bbe_bank_map u_map (
    .req      (in_word),
    .issue_wr (accept && ok && (in_word.opcode == bbe_pkg::OP_WRITE)),
    .issue_rd (accept && ok && (in_word.opcode == bbe_pkg::OP_READ)),
    .clr      (state_r == S_CLEAR),
    .clr_row  (clr_row_r),
    .bank_req (bank_req)
  );

  for (genvar b = 0; b < bbe_pkg::NUM_BANKS; b++) begin : g_bank
    bbe_ram #(
      .WIDTH (8),
      .DEPTH (bbe_pkg::BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_req[b].we),
      .re    (bank_req[b].re),
      .addr  (bank_req[b].row),
      .wdata (bank_req[b].wdata),
      .rdata (bank_rdata[b])
    );
  end

  // Big-endian assembly: first byte sits in bank off
  function automatic logic [31:0] assemble(
    input logic [bbe_pkg::NUM_BANKS-1:0][7:0] bytes,
    input logic [1:0]                         off,
    input logic [1:0]                         code
  );
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] v;
    b0 = bytes[off];
    b1 = bytes[off + 2'd1];
    b2 = bytes[off + 2'd2];
    b3 = bytes[off + 2'd3];
    case (code)
      bbe_pkg::SZ_BYTE: v = {24'd0, b0};
      bbe_pkg::SZ_WORD: v = {16'd0, b0, b1};
      default:          v = {b0, b1, b2, b3};
    endcase
    return v;
  endfunction

  // Control: clearing pass, then one pending word at a time
  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + bbe_pkg::ROW_W'(1);
        if (clr_row_r == LAST_ROW) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_BUSY;
      end
      S_BUSY: begin
        if (out_load && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Pending word bookkeeping
  assign pend_status_nxt = accept ? status : pend_status_r;
  assign pend_rd_nxt     = accept ? (ok && (in_word.opcode == bbe_pkg::OP_READ))
                                  : pend_rd_r;
  assign pend_off_nxt    = accept ? in_word.address[1:0] : pend_off_r;
  assign pend_code_nxt   = accept ? in_word.access_size : pend_code_r;

  // Output register
  always_comb begin
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt          = 1'b1;
      out_word_nxt.status    = pend_status_r;
      out_word_nxt.read_data = pend_rd_r ? assemble(bank_rdata, pend_off_r, pend_code_r)
                                         : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      size_r      <= SLOT_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_rd_r     <= pend_rd_nxt;
    pend_off_r    <= pend_off_nxt;
    pend_code_r   <= pend_code_nxt;
    out_word_r    <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  a_clear_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("word accepted during clearing pass");

  a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("output valid during clearing pass");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != bbe_pkg::ST_OK)) |-> (out_word_r.read_data == 32'd0))
    else $error("failed access returned nonzero data");

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_BUSY) && !out_load) |=> (state_r == S_BUSY))
    else $error("pending word dropped");

endmodule
